// ===== hw/rtl/ccks_pkg.sv =====
// ----------------------------------------------------------------------------
// ChaCha20 keystream package
// Shared types and constants for the ChaCha20 byte cipher.
// ----------------------------------------------------------------------------
`default_nettype none
package ccks_pkg;
  localparam logic [31:0] SIGMA0 = 32'h61707865;
  localparam logic [31:0] SIGMA1 = 32'h3320646e;
  localparam logic [31:0] SIGMA2 = 32'h79622d32;
  localparam logic [31:0] TAU1   = 32'h3120646e;
  localparam logic [31:0] TAU2   = 32'h79622d36;
  localparam logic [31:0] SIGMA3 = 32'h6b206574;

  localparam int unsigned CFG_IDX_W = 3;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t REG_KEY01   = 3'd0;
  localparam cfg_idx_t REG_KEY23   = 3'd1;
  localparam cfg_idx_t REG_KEY45   = 3'd2;
  localparam cfg_idx_t REG_KEY67   = 3'd3;
  localparam cfg_idx_t REG_SHORT   = 3'd4;
  localparam cfg_idx_t REG_BLK1213 = 3'd5;
  localparam cfg_idx_t REG_BLK1415 = 3'd6;

  typedef logic [31:0] word_t;
  typedef logic [3:0]  widx_t;

  // Quarter-round step: rotate a word left by n bits.
  function automatic word_t rotl(input word_t v, input logic [4:0] n);
    rotl = (v << n) | (v >> (6'd32 - {1'b0, n}));
  endfunction

  // Word indexes a,b,c,d of quarter round q (0..7) within a double round.
  function automatic logic [15:0] qr_idx(input logic [2:0] q);
    case (q)
      3'd0: qr_idx = {4'd0, 4'd4, 4'd8,  4'd12};
      3'd1: qr_idx = {4'd1, 4'd5, 4'd9,  4'd13};
      3'd2: qr_idx = {4'd2, 4'd6, 4'd10, 4'd14};
      3'd3: qr_idx = {4'd3, 4'd7, 4'd11, 4'd15};
      3'd4: qr_idx = {4'd0, 4'd5, 4'd10, 4'd15};
      3'd5: qr_idx = {4'd1, 4'd6, 4'd11, 4'd12};
      3'd6: qr_idx = {4'd2, 4'd7, 4'd8,  4'd13};
      default: qr_idx = {4'd3, 4'd4, 4'd9, 4'd14};
    endcase
  endfunction
endpackage
`default_nettype wire

// ===== hw/rtl/ccks_stream_if.sv =====
// ----------------------------------------------------------------------------
// Byte stream interface
// Valid/ready channel carrying one byte.
// ----------------------------------------------------------------------------
`default_nettype none
interface ccks_stream_if;
  logic       valid;
  logic       ready;
  logic [7:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/ccks_cfg_if.sv =====
// ----------------------------------------------------------------------------
// Configuration write interface
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
`default_nettype none
interface ccks_cfg_if;
  logic                     valid;
  logic                     ready;
  logic [ccks_pkg::CFG_IDX_W-1:0] index;
  logic [63:0]              data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/ccks_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module ccks_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== hw/rtl/ccks_block_gen.sv =====
// ----------------------------------------------------------------------------
// ChaCha20 block generator
// Runs the rounds over a working-state RAM with one shared quarter-round
// datapath, then adds the input words and writes the keystream RAM.
// ----------------------------------------------------------------------------
`default_nettype none
module ccks_block_gen #(
  parameter int DOUBLE_ROUNDS = 10
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  input  wire logic [511:0]         init_words,
  output      logic                 busy,
  output      logic                 ks_we,
  output      logic [3:0]           ks_waddr,
  output      logic [31:0]          ks_wdata
);
  import ccks_pkg::*;

  localparam int DR_W = $clog2(DOUBLE_ROUNDS);

  // Sequencer: LOAD writes init words, for each quarter round READ four words
  // (one per cycle, registered), WRITE computes the quarter round and writes
  // the four words back, FINAL reads each word and adds the input word.
  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_LOAD  = 6'b000010,
    S_READ  = 6'b000100,
    S_WRITE = 6'b001000,
    S_FINAL = 6'b010000,
    S_FDONE = 6'b100000
  } state_t;

  state_t           state_r, state_nxt;
  logic [3:0]       cnt_r, cnt_nxt;
  logic [2:0]       qr_r, qr_nxt;
  logic [DR_W-1:0]  dr_r, dr_nxt;
  word_t            wa_r, wb_r, wc_r, wd_r;
  logic             rd_pend_r;
  logic [1:0]       rd_sel_r;
  logic [3:0]       fin_idx_r;

  logic        we;
  logic [3:0]  waddr, raddr;
  word_t       wdata, rdata;
  logic [15:0] idx;
  word_t       a1, d1, c1, b1, a2, d2, c2, b2;
  word_t       init_w;

  ccks_ram #(.WIDTH(32), .DEPTH(16)) u_work (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr(raddr), .rdata(rdata)
  );

  assign idx = qr_idx(qr_r);
  assign init_w = init_words[fin_idx_r*32 +: 32];

  // Quarter round on the four gathered words.
  always_comb begin
    a1 = wa_r + wb_r;     d1 = rotl(wd_r ^ a1, 5'd16);
    c1 = wc_r + d1;       b1 = rotl(wb_r ^ c1, 5'd12);
    a2 = a1 + b1;         d2 = rotl(d1 ^ a2, 5'd8);
    c2 = c1 + d2;         b2 = rotl(b1 ^ c2, 5'd7);
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    qr_nxt    = qr_r;
    dr_nxt    = dr_r;
    we        = 1'b0;
    waddr     = cnt_r;
    wdata     = init_words[cnt_r*32 +: 32];
    raddr     = cnt_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = S_LOAD;
          cnt_nxt   = '0;
        end
      end
      S_LOAD: begin
        we = 1'b1;
        cnt_nxt = cnt_r + 4'd1;
        if (cnt_r == 4'd15) begin
          state_nxt = S_READ;
          cnt_nxt   = '0;
          qr_nxt    = '0;
          dr_nxt    = '0;
        end
      end
      S_READ: begin
        raddr = idx[15 - cnt_r[1:0]*4 -: 4];
        cnt_nxt = cnt_r + 4'd1;
        if (cnt_r == 4'd4) begin
          state_nxt = S_WRITE;
          cnt_nxt   = '0;
        end
      end
      S_WRITE: begin
        we = 1'b1;
        waddr = idx[15 - cnt_r[1:0]*4 -: 4];
        case (cnt_r[1:0])
          2'd0:    wdata = a2;
          2'd1:    wdata = b2;
          2'd2:    wdata = c2;
          default: wdata = d2;
        endcase
        cnt_nxt = cnt_r + 4'd1;
        if (cnt_r == 4'd3) begin
          cnt_nxt = '0;
          qr_nxt  = qr_r + 3'd1;
          state_nxt = S_READ;
          if (qr_r == 3'd7) begin
            dr_nxt = dr_r + DR_W'(1);
            if (dr_r == DR_W'(DOUBLE_ROUNDS - 1)) state_nxt = S_FINAL;
          end
        end
      end
      S_FINAL: begin
        raddr = cnt_r;
        cnt_nxt = cnt_r + 4'd1;
        if (cnt_r == 4'd15) state_nxt = S_FDONE;
      end
      S_FDONE: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      cnt_r     <= '0;
      qr_r      <= '0;
      dr_r      <= '0;
      rd_pend_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      qr_r      <= qr_nxt;
      dr_r      <= dr_nxt;
      rd_pend_r <= (state_r == S_READ && cnt_r != 4'd4) || state_r == S_FINAL;
    end
    rd_sel_r  <= cnt_r[1:0];
    fin_idx_r <= cnt_r;
    // Read data arrives in the cycle after its address.
    if (rd_pend_r && state_r == S_READ) begin
      case (rd_sel_r)
        2'd0:    wa_r <= rdata;
        2'd1:    wb_r <= rdata;
        2'd2:    wc_r <= rdata;
        default: wd_r <= rdata;
      endcase
    end
  end

  assign busy     = (state_r != S_IDLE);
  assign ks_we    = rd_pend_r && (state_r == S_FINAL || state_r == S_FDONE);
  assign ks_waddr = fin_idx_r;
  assign ks_wdata = rdata + init_w;
endmodule
`default_nettype wire

// ===== hw/rtl/chacha20_keystream_cipher_core.sv =====
// ----------------------------------------------------------------------------
// ChaCha20 keystream cipher core
// XORs each input byte with the next ChaCha20 keystream byte.
// ----------------------------------------------------------------------------
// Usage: bytes arrive on the in_ channel and leave on the out_ channel, one
// result per transfer, in order. The cfg_ channel writes the key, the
// short-key flag and state words 12 to 15; any write to registers 0 to 6
// restarts the byte position at zero and reloads the 64-bit block counter.
// Write only while the core is idle.
// Sequence: a byte that does not start a block is taken in an idle cycle,
// its keystream word is read in the next cycle, and the result is valid from
// the output register in the cycle after that. The next byte is taken only
// once that result has been accepted.
// A byte at position zero first waits for a new block: the init words are
// loaded, DOUBLE_ROUNDS*8 quarter rounds run on the shared quarter-round
// unit over the working-state RAM, and the final add fills the keystream
// RAM. The control sequence, which keeps one byte in flight at a time,
// bounds the byte rate.
// Reset clears position, counter and configuration registers; no clearing
// pass is needed. When the receiver stalls, the result is held in the output
// register and no new byte is taken until it is gone.
// ----------------------------------------------------------------------------
`default_nettype none
module chacha20_keystream_cipher_core #(
  parameter int DOUBLE_ROUNDS = 10
) (
  input wire logic  clk,
  input wire logic  rst_n,
  ccks_stream_if.sink   in_,
  ccks_stream_if.source out_,
  ccks_cfg_if.sink      cfg_
);
  import ccks_pkg::*;

  typedef enum logic [4:0] {
    C_IDLE = 5'b00001,
    C_GEN  = 5'b00010,
    C_WAIT = 5'b00100,
    C_READ = 5'b01000,
    C_OUT  = 5'b10000
  } cstate_t;

  cstate_t     state_r, state_nxt;
  logic [63:0] key01_r, key23_r, key45_r, key67_r, blk1213_r, blk1415_r;
  logic        short_r;
  logic [63:0] ctr_r;
  logic [5:0]  pos_r;
  logic [7:0]  byte_r;
  logic [7:0]  out_r;
  logic        gen_start;
  logic        gen_busy;
  logic        ks_we;
  logic [3:0]  ks_waddr;
  word_t       ks_wdata, ks_rdata;
  logic [511:0] init_words;
  logic        in_xfer, cfg_xfer;

  assign in_xfer  = in_.valid && in_.ready;
  assign cfg_xfer = cfg_.valid && cfg_.ready;
  assign cfg_.ready = 1'b1;
  assign in_.ready  = (state_r == C_IDLE);

  // Input state words 0..15, word i at bits 32*i.
  always_comb begin
    init_words[31:0]    = SIGMA0;
    init_words[63:32]   = short_r ? TAU1 : SIGMA1;
    init_words[95:64]   = short_r ? TAU2 : SIGMA2;
    init_words[127:96]  = SIGMA3;
    init_words[191:128] = key01_r;
    init_words[255:192] = key23_r;
    init_words[319:256] = short_r ? key01_r : key45_r;
    init_words[383:320] = short_r ? key23_r : key67_r;
    init_words[447:384] = ctr_r;
    init_words[511:448] = blk1415_r;
  end

  ccks_block_gen #(.DOUBLE_ROUNDS(DOUBLE_ROUNDS)) u_gen (
    .clk(clk), .rst_n(rst_n), .start(gen_start), .init_words(init_words),
    .busy(gen_busy), .ks_we(ks_we), .ks_waddr(ks_waddr), .ks_wdata(ks_wdata)
  );

  // Keystream block store; the read address is the word of the current byte.
  ccks_ram #(.WIDTH(32), .DEPTH(16)) u_ks (
    .clk(clk), .we(ks_we), .waddr(ks_waddr), .wdata(ks_wdata),
    .raddr(pos_r[5:2]), .rdata(ks_rdata)
  );

  assign gen_start = (state_r == C_GEN);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      C_IDLE: if (in_xfer) state_nxt = (pos_r == '0) ? C_GEN : C_READ;
      C_GEN:  state_nxt = C_WAIT;
      C_WAIT: if (!gen_busy) state_nxt = C_READ;
      C_READ: state_nxt = C_OUT;
      C_OUT:  if (out_.ready) state_nxt = C_IDLE;
      default: state_nxt = C_IDLE;
    endcase
  end

  assign out_.valid = (state_r == C_OUT);
  assign out_.data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= C_IDLE;
      key01_r <= '0; key23_r <= '0; key45_r <= '0; key67_r <= '0;
      short_r <= 1'b0; blk1213_r <= '0; blk1415_r <= '0;
      ctr_r   <= '0;
      pos_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_xfer) begin
        unique case (cfg_.index)
          REG_KEY01:   key01_r   <= cfg_.data;
          REG_KEY23:   key23_r   <= cfg_.data;
          REG_KEY45:   key45_r   <= cfg_.data;
          REG_KEY67:   key67_r   <= cfg_.data;
          REG_SHORT:   short_r   <= cfg_.data[0];
          REG_BLK1213: blk1213_r <= cfg_.data;
          REG_BLK1415: blk1415_r <= cfg_.data;
          default: ;
        endcase
        if (cfg_.index <= REG_BLK1415) begin
          pos_r <= '0;
          ctr_r <= (cfg_.index == REG_BLK1213) ? cfg_.data : blk1213_r;
        end
      end
      // Counter advances once the generator has finished the block.
      if (state_r == C_WAIT && !gen_busy) ctr_r <= ctr_r + 64'd1;
      if (state_r == C_READ) pos_r <= pos_r + 6'd1;
    end
    if (in_xfer) byte_r <= in_.data;
    if (state_r == C_READ) out_r <= byte_r ^ ks_rdata[pos_r[1:0]*8 +: 8];
  end

`ifndef NO_ASSERTIONS
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_.valid && !out_.ready |=> out_.valid && $stable(out_.data))
    else $error("result lost while stalled");
  a_gen_only_at_zero: assert property (@(posedge clk) disable iff (!rst_n)
    gen_start |-> pos_r == 6'd0)
    else $error("block started off position zero");
  a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_.ready |-> !gen_busy)
    else $error("input taken while generator busy");
  a_pos_step: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == C_READ && !cfg_xfer |=> pos_r == $past(pos_r) + 6'd1)
    else $error("position did not advance");
`endif
endmodule
`default_nettype wire

// ===== tb/tb_chacha20_keystream_cipher_core.sv =====
// ----------------------------------------------------------------------------
// ChaCha20 keystream cipher core testbench
// Streams bytes through the core under random idling on both channels and
// checks every result against a ChaCha20 block predictor kept in the bench.
// Configuration phases cover long and short keys, counter wrap and extremes.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_top;
  import ccks_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  always #6 clk = ~clk;

  ccks_stream_if in_if ();
  ccks_stream_if out_if ();
  ccks_cfg_if    cfg_if ();

  chacha20_keystream_cipher_core dut (
    .clk  (clk),
    .rst_n(rst_n),
    .in_  (in_if),
    .out_ (out_if),
    .cfg_ (cfg_if)
  );

  // Predictor state: configuration copy, running counter, current block.
  logic [63:0] cfg_shadow [7];
  logic [63:0] ctr_model;
  word_t       ks_block [16];
  logic [5:0]  pos_model;

  logic [7:0]  byte_queue [$];   // bytes waiting for the driver
  logic [7:0]  cipher_expect [$];// predicted result bytes, oldest first
  int          fail_count = 0;

  // Transfers seen at the last rising edge, one flag per channel.
  logic        in_acc = 1'b0;
  logic        out_acc = 1'b0;
  logic        cfg_acc = 1'b0;

  // Configuration transfer request, served by the cfg driver below.
  logic        cfg_req = 1'b0;
  cfg_idx_t    cfg_req_idx;
  logic [63:0] cfg_req_data;
  logic        cfg_ack = 1'b0;

  function automatic word_t rot_left(word_t v, int n);
    return (v << n) | (v >> (32 - n));
  endfunction

  // Builds the next 64-byte keystream block and advances the block counter.
  task automatic build_block();
    word_t s [16];
    word_t w [16];
    bit    is_short;
    int    qa [8], qb [8], qc [8], qd [8];
    is_short = cfg_shadow[REG_SHORT][0];
    qa = '{0, 1, 2, 3, 0, 1, 2, 3};
    qb = '{4, 5, 6, 7, 5, 6, 7, 4};
    qc = '{8, 9, 10, 11, 10, 11, 8, 9};
    qd = '{12, 13, 14, 15, 15, 12, 13, 14};
    s[0] = 32'h61707865;
    s[1] = is_short ? 32'h3120646e : 32'h3320646e;
    s[2] = is_short ? 32'h79622d36 : 32'h79622d32;
    s[3] = 32'h6b206574;
    for (int i = 0; i < 4; i++) begin
      s[4 + 2*i] = cfg_shadow[i][31:0];
      s[5 + 2*i] = cfg_shadow[i][63:32];
    end
    if (is_short) begin
      for (int i = 0; i < 4; i++) s[8 + i] = s[4 + i];
    end
    s[12] = ctr_model[31:0];
    s[13] = ctr_model[63:32];
    s[14] = cfg_shadow[REG_BLK1415][31:0];
    s[15] = cfg_shadow[REG_BLK1415][63:32];
    w = s;
    for (int r = 0; r < 10; r++) begin
      for (int q = 0; q < 8; q++) begin
        w[qa[q]] += w[qb[q]]; w[qd[q]] = rot_left(w[qd[q]] ^ w[qa[q]], 16);
        w[qc[q]] += w[qd[q]]; w[qb[q]] = rot_left(w[qb[q]] ^ w[qc[q]], 12);
        w[qa[q]] += w[qb[q]]; w[qd[q]] = rot_left(w[qd[q]] ^ w[qa[q]], 8);
        w[qc[q]] += w[qd[q]]; w[qb[q]] = rot_left(w[qb[q]] ^ w[qc[q]], 7);
      end
    end
    for (int i = 0; i < 16; i++) ks_block[i] = w[i] + s[i];
    ctr_model = ctr_model + 64'd1;
  endtask

  // Predicts the result of one accepted byte.
  task automatic predict_cipher(input logic [7:0] b);
    word_t wsel;
    if (pos_model == 6'd0) build_block();
    wsel = ks_block[pos_model[5:2]];
    cipher_expect.push_back(b ^ wsel[8*pos_model[1:0] +: 8]);
    pos_model = pos_model + 6'd1;
  endtask

  // Input driver: changes at falling edges, waits a random gap per byte.
  int in_gap = 0;
  initial begin
    in_if.valid = 1'b0;
    in_if.data  = 8'h00;
  end
  always @(negedge clk) begin
    int gap;
    if (in_acc) begin
      // Transfer happened at the last rising edge.
      void'(byte_queue.pop_front());
      gap = $urandom_range(0, 17);
      if (gap == 0 && byte_queue.size() > 0) begin
        in_if.data <= byte_queue[0];
      end else begin
        in_if.valid <= 1'b0;
        in_gap <= gap;
      end
    end else if (!in_if.valid && byte_queue.size() > 0 && rst_n) begin
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
      end else begin
        in_if.valid <= 1'b1;
        in_if.data  <= byte_queue[0];
      end
    end
  end

  // Predict at the rising edge where a byte transfers.
  always @(posedge clk) begin
    in_acc <= rst_n && in_if.valid && in_if.ready;
    if (rst_n && in_if.valid && in_if.ready) predict_cipher(in_if.data);
  end

  // Output side: random stalls per result, compares at rising edges.
  int out_gap = 0;
  initial out_if.ready = 1'b0;
  always @(negedge clk) begin
    int gap;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else if (out_acc) begin
      gap = $urandom_range(0, 17);
      if (gap == 0) begin
        out_if.ready <= 1'b1;
      end else begin
        out_if.ready <= 1'b0;
        out_gap <= gap;
      end
    end else if (!out_if.ready) begin
      if (out_gap > 0) out_gap <= out_gap - 1;
      else out_if.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    logic [7:0] exp_byte;
    out_acc <= rst_n && out_if.valid && out_if.ready;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (cipher_expect.size() == 0) begin
        $error("out_byte: unexpected result 0x%02h", out_if.data);
        fail_count++;
      end else begin
        exp_byte = cipher_expect.pop_front();
        if (out_if.data !== exp_byte) begin
          $error("out_byte: expected 0x%02h, actual 0x%02h", exp_byte, out_if.data);
          fail_count++;
        end
      end
    end
  end

  // Configuration driver.
  initial begin
    cfg_if.valid = 1'b0;
    cfg_if.index = REG_KEY01;
    cfg_if.data  = 64'd0;
  end
  always @(posedge clk) begin
    cfg_acc <= rst_n && cfg_if.valid && cfg_if.ready;
  end
  always @(negedge clk) begin
    cfg_ack <= cfg_acc;
    if (cfg_acc) begin
      cfg_if.valid <= 1'b0;
    end else if (cfg_req && !cfg_if.valid && !cfg_ack) begin
      cfg_if.valid <= 1'b1;
      cfg_if.index <= cfg_req_idx;
      cfg_if.data  <= cfg_req_data;
    end
  end

  // Writes one register and mirrors it in the predictor.
  task automatic write_reg(input cfg_idx_t idx, input logic [63:0] val);
    cfg_req_idx  = idx;
    cfg_req_data = val;
    cfg_req      = 1'b1;
    @(posedge cfg_ack);
    cfg_req = 1'b0;
    @(negedge clk);
    cfg_shadow[idx] = (idx == REG_SHORT) ? {63'd0, val[0]} : val;
    ctr_model = cfg_shadow[REG_BLK1213];
    pos_model = 6'd0;
  endtask

  task automatic drain_phase();
    wait (byte_queue.size() == 0 && cipher_expect.size() == 0);
    // No block build is still running after the last result; the bench idles before the next phase.
    repeat (1000) @(negedge clk);
  endtask

  task automatic send_random(input int n);
    for (int i = 0; i < n; i++) byte_queue.push_back(8'($urandom));
  endtask

  task automatic random_config(input bit short_key, input logic [63:0] ctr);
    write_reg(REG_KEY01, {$urandom, $urandom});
    write_reg(REG_KEY23, {$urandom, $urandom});
    write_reg(REG_KEY45, {$urandom, $urandom});
    write_reg(REG_KEY67, {$urandom, $urandom});
    write_reg(REG_SHORT, {63'd0, short_key});
    write_reg(REG_BLK1415, {$urandom, $urandom});
    write_reg(REG_BLK1213, ctr);
  endtask

  initial begin
    for (int i = 0; i < 7; i++) cfg_shadow[i] = 64'd0;
    ctr_model = 64'd0;
    pos_model = 6'd0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: reset configuration, byte extremes, 24 bytes of the first block.
    byte_queue.push_back(8'h00);
    byte_queue.push_back(8'hff);
    byte_queue.push_back(8'h55);
    byte_queue.push_back(8'haa);
    send_random(20);
    drain_phase();

    // All-ones key, long key, counter about to wrap across a block boundary.
    write_reg(REG_KEY01, '1);
    write_reg(REG_KEY23, '1);
    write_reg(REG_KEY45, '1);
    write_reg(REG_KEY67, '1);
    write_reg(REG_BLK1415, '1);
    write_reg(REG_BLK1213, '1);
    send_random(70);
    drain_phase();

    // Short key, with a wide value whose upper bits are dropped.
    write_reg(REG_SHORT, 64'hffff_ffff_ffff_fffe);
    write_reg(REG_SHORT, '1);
    send_random(70);
    drain_phase();

    // A write mid-block restarts the position.
    send_random(10);
    drain_phase();
    write_reg(REG_KEY45, 64'd0);
    send_random(5);
    drain_phase();

    // Random phases, both key sizes, counter near wrap in one.
    for (int p = 0; p < 6; p++) begin
      random_config(p[0], p == 2 ? 64'hffff_ffff_ffff_ffff - 1 : {$urandom, $urandom});
      send_random(80 + $urandom_range(0, 40));
      drain_phase();
    end
    write_reg(REG_SHORT, 64'd0);
    write_reg(REG_BLK1213, 64'd0);
    send_random(100);
    drain_phase();

    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #6000000;
    $display("CHECKS FAILED");
    $finish;
  end
endmodule
`default_nettype wire
